/* sv/lcd_shadow_diff_refresh_macros.svh */
// Assertion macros shared by the refresh block.
`ifndef LCD_SHADOW_DIFF_REFRESH_MACROS_SVH
`define LCD_SHADOW_DIFF_REFRESH_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LCDSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LCDSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lcdsd_pkg.sv */
`default_nettype none

package lcdsd_pkg;

    // Operations carried by an input beat.
    localparam logic [1:0] OP_SET     = 2'd0;
    localparam logic [1:0] OP_CLEAR   = 2'd1;
    localparam logic [1:0] OP_REFRESH = 2'd2;
    localparam logic [1:0] OP_SCAN    = 2'd3;

    // Result commands.
    localparam logic [1:0] CMD_NONE      = 2'd0;
    localparam logic [1:0] CMD_CURSOR_LO = 2'd1;
    localparam logic [1:0] CMD_CURSOR_HI = 2'd2;
    localparam logic [1:0] CMD_DATA      = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_UPSIDE = 3'd2;
    localparam logic [2:0] REG_INVERT = 3'd3;
    localparam logic [2:0] REG_PERIOD = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam int DEF_WIDTH  = 240;
    localparam int DEF_HEIGHT = 128;

    localparam logic [7:0] INVERT_MASK = 8'hff;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] column;
        logic [6:0] row;
        logic [7:0] pixel_byte;
        logic       force_full;
    } t_in_item;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] value;
        logic       last;
        logic       frame_done;
    } t_out_item;

endpackage

`default_nettype wire

/* sv/lcd_shadow_diff_refresh.sv */
// Channel  | Direction | Handshake                  | Beat
// ---------+-----------+----------------------------+--------------------------
// in       | input     | i_in_valid / o_in_ready    | i_in_data (t_in_item)
// out      | output    | o_out_valid / i_out_ready  | o_out_data (t_out_item)
// cfg      | input     | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// One item at a time. Set pixels reads, then writes back the OR; begin refresh
// goes back to idle, or first waits while the period counter runs its 9-step remainder.
// A scan step reads both frame stores and compares, then emits one result beat per
// cycle (up to 3) while the output side takes them.
// Clear sweeps STRIDE * MAX_HEIGHT entries, one a cycle; after reset a like pass zeroes
// both frames before any input beat is taken. A held output beat stalls its step's
// remaining results and the input with them, but not once the last result is held.
`default_nettype none

`include "lcd_shadow_diff_refresh_macros.svh"

module lcd_shadow_diff_refresh
    import lcdsd_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 128
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int STRIDE = (MAX_WIDTH + 7) / 8;
    localparam int FRAME  = STRIDE * MAX_HEIGHT;
    localparam int AW     = (FRAME > 1) ? $clog2(FRAME) : 1;
    localparam int CLW    = $clog2(STRIDE + 1);
    localparam int RW     = $clog2(MAX_HEIGHT + 1);
    localparam int PW     = RW + CLW + 1;
    localparam int WBITS  = $clog2(MAX_WIDTH + 1);
    localparam int HBITS  = $clog2(MAX_HEIGHT + 1);
    localparam int CW     = (WBITS > 9) ? WBITS : 9;
    localparam int HC     = (HBITS > 8) ? HBITS : 8;
    localparam logic [AW-1:0] LAST_ENTRY = AW'(FRAME - 1);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_LOOK = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_CLR  = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    function automatic logic [7:0] flip_bits(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7 - i] = b[i];
        end
        return r;
    endfunction

    function automatic t_out_item mk_out(input logic [1:0] cmd, input logic [7:0] val,
                                         input logic lst, input logic done);
        t_out_item o;
        o.command    = cmd;
        o.value      = val;
        o.last       = lst;
        o.frame_done = done;
        return o;
    endfunction

    function automatic logic [AW-1:0] entry_of(input logic [RW-1:0] row,
                                               input logic [CLW-1:0] col);
        logic [PW-1:0] p;
        p = PW'(row) * PW'(STRIDE) + PW'(col);
        return p[AW-1:0];
    endfunction

    // Configuration.
    logic [8:0] r_cfg_width;
    logic [7:0] r_cfg_height;
    logic       r_upside;
    logic       r_invert;
    logic [7:0] r_period;

    // Control.
    logic [2:0]     r_state;
    logic [AW-1:0]  r_sweep;
    t_in_item       r_item;
    logic [AW-1:0]  r_idx;
    logic [7:0]     r_wbyte;
    logic [RW-1:0]  r_scan_row;
    logic [CLW-1:0] r_scan_col;
    logic [15:0]    r_scan_addr;
    logic           r_scanning;
    logic           r_full;
    logic           r_run_open;
    logic [7:0]     r_period_count;
    t_out_item      r_res [3];
    logic [1:0]     r_res_ptr;
    logic           r_out_valid;
    t_out_item      r_out;

    // Frame stores.
    logic          want_en, want_we, shown_en, shown_we;
    logic [AW-1:0] want_addr, shown_addr;
    logic [7:0]    want_wdata, shown_wdata, want_rdata, shown_rdata;

    // Remainder unit.
    logic       rem_start, rem_done;
    logic [7:0] rem_value;

    // Derived values.
    logic [CW-1:0]  w0, eff_w, px_x;
    logic [HC-1:0]  h0, eff_h, px_y;
    logic [CW:0]    bpl;
    logic           px_in, scan_oob;
    logic [AW-1:0]  px_idx, scan_idx;
    logic [CLW-1:0] col_inc;
    logic           col_wrap;
    logic [RW-1:0]  row_inc;
    logic           scan_done;
    logic           cmp_send, cmp_lead;
    logic [7:0]     cmp_data;
    logic           refresh_full;
    logic           out_free;
    logic           n_out_valid;

    always_comb begin
        w0    = (r_cfg_width == '0) ? CW'(DEF_WIDTH) : CW'(r_cfg_width);
        eff_w = (w0 > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : w0;
        h0    = (r_cfg_height == '0) ? HC'(DEF_HEIGHT) : HC'(r_cfg_height);
        eff_h = (h0 > HC'(MAX_HEIGHT)) ? HC'(MAX_HEIGHT) : h0;
        bpl   = ({1'b0, eff_w} + (CW + 1)'(7)) >> 3;

        // Pixel write target; upside down mirrors both axes.
        px_in = (CW'(r_item.column) < eff_w) && (HC'(r_item.row) < eff_h);
        px_x  = r_upside ? (eff_w - CW'(1) - CW'(r_item.column)) : CW'(r_item.column);
        px_y  = r_upside ? (eff_h - HC'(1) - HC'(r_item.row)) : HC'(r_item.row);
        px_idx = entry_of(px_y[RW-1:0], CLW'(px_x >> 3));

        scan_oob = (HC'(r_scan_row) >= eff_h) || ((CW + 1)'(r_scan_col) >= bpl);
        scan_idx = entry_of(r_scan_row, r_scan_col);

        col_inc   = r_scan_col + CLW'(1);
        col_wrap  = (CW + 1)'(col_inc) >= bpl;
        row_inc   = col_wrap ? (r_scan_row + RW'(1)) : r_scan_row;
        scan_done = HC'(row_inc) >= eff_h;

        cmp_send = r_full || (want_rdata != shown_rdata);
        cmp_lead = r_full || !r_run_open;
        cmp_data = want_rdata ^ (r_invert ? INVERT_MASK : 8'h00);

        refresh_full = r_item.force_full || (rem_value == 8'd0);
        out_free     = !r_out_valid || i_out_ready;
        n_out_valid  = ((r_state == S_EMIT) && out_free) || (r_out_valid && !i_out_ready);
    end

    // Store port selection by state.
    always_comb begin
        want_en    = 1'b0;
        want_we    = 1'b0;
        want_addr  = r_idx;
        want_wdata = want_rdata | r_wbyte;
        shown_en    = 1'b0;
        shown_we    = 1'b0;
        shown_addr  = r_idx;
        shown_wdata = want_rdata;
        unique case (r_state)
            S_INIT: begin
                want_en    = 1'b1;
                want_we    = 1'b1;
                want_addr  = r_sweep;
                want_wdata = '0;
                shown_en    = 1'b1;
                shown_we    = 1'b1;
                shown_addr  = r_sweep;
                shown_wdata = '0;
            end
            S_CLR: begin
                want_en    = 1'b1;
                want_we    = 1'b1;
                want_addr  = r_sweep;
                want_wdata = '0;
            end
            S_LOOK: begin
                if (r_item.operation == OP_SET) begin
                    want_en   = px_in;
                    want_addr = px_idx;
                end else if (r_item.operation == OP_SCAN) begin
                    want_en    = r_scanning && !scan_oob;
                    want_addr  = scan_idx;
                    shown_en   = r_scanning && !scan_oob;
                    shown_addr = scan_idx;
                end
            end
            S_MOD: begin
                want_en = 1'b1;
                want_we = 1'b1;
            end
            S_CMP: begin
                shown_en = cmp_send;
                shown_we = cmp_send;
            end
            S_IDLE, S_DIV, S_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    assign rem_start = (r_state == S_LOOK) && (r_item.operation == OP_REFRESH)
                       && (r_period != 8'd0);

    lcdsd_ram #(.WIDTH(8), .DEPTH(FRAME)) u_wanted (
        .i_clk   (i_clk),
        .i_en    (want_en),
        .i_we    (want_we),
        .i_addr  (want_addr),
        .i_wdata (want_wdata),
        .o_rdata (want_rdata)
    );

    lcdsd_ram #(.WIDTH(8), .DEPTH(FRAME)) u_shown (
        .i_clk   (i_clk),
        .i_en    (shown_en),
        .i_we    (shown_we),
        .i_addr  (shown_addr),
        .i_wdata (shown_wdata),
        .o_rdata (shown_rdata)
    );

    lcdsd_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend ({1'b0, r_period_count} + 9'd1),
        .i_divisor  (r_period),
        .o_done     (rem_done),
        .o_rem      (rem_value)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= 9'(DEF_WIDTH);
            r_cfg_height <= 8'(DEF_HEIGHT);
            r_upside     <= 1'b0;
            r_invert     <= 1'b0;
            r_period     <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH:  r_cfg_width  <= i_cfg_data;
                REG_HEIGHT: r_cfg_height <= i_cfg_data[7:0];
                REG_UPSIDE: r_upside     <= i_cfg_data[0];
                REG_INVERT: r_invert     <= i_cfg_data[0];
                REG_PERIOD: r_period     <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_INIT;
            r_sweep        <= '0;
            r_scan_row     <= '0;
            r_scan_col     <= '0;
            r_scan_addr    <= '0;
            r_scanning     <= 1'b0;
            r_full         <= 1'b0;
            r_run_open     <= 1'b0;
            r_period_count <= '0;
            r_res_ptr      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_INIT, S_CLR: begin
                    r_sweep <= r_sweep + AW'(1);
                    if (r_sweep == LAST_ENTRY) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_data;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    unique case (r_item.operation)
                        OP_SET: begin
                            r_idx   <= px_idx;
                            r_wbyte <= r_upside ? r_item.pixel_byte
                                                : flip_bits(r_item.pixel_byte);
                            r_state <= px_in ? S_MOD : S_IDLE;
                        end
                        OP_CLEAR: begin
                            r_sweep <= '0;
                            r_state <= S_CLR;
                        end
                        OP_REFRESH: begin
                            r_scanning  <= 1'b1;
                            r_run_open  <= 1'b0;
                            r_scan_row  <= '0;
                            r_scan_col  <= '0;
                            r_scan_addr <= '0;
                            if (r_period == 8'd0) begin
                                r_full <= r_item.force_full;
                                if (r_item.force_full) begin
                                    r_period_count <= '0;
                                end
                                r_state <= S_IDLE;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                        OP_SCAN: begin
                            r_res_ptr <= '0;
                            if (!r_scanning) begin
                                r_state <= S_IDLE;
                            end else if (scan_oob) begin
                                // Frame shrank under a running scan: end it here.
                                r_scanning <= 1'b0;
                                r_res[0]   <= mk_out(CMD_NONE, 8'h00, 1'b1, 1'b1);
                                r_state    <= S_EMIT;
                            end else begin
                                r_idx   <= scan_idx;
                                r_state <= S_CMP;
                            end
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_MOD: begin
                    r_state <= S_IDLE;
                end
                S_DIV: begin
                    if (rem_done) begin
                        r_full         <= refresh_full;
                        r_period_count <= refresh_full ? 8'd0 : rem_value;
                        r_state        <= S_IDLE;
                    end
                end
                S_CMP: begin
                    r_scan_addr <= r_scan_addr + 16'd1;
                    r_scan_col  <= col_wrap ? '0 : col_inc;
                    r_scan_row  <= row_inc;
                    if (scan_done) begin
                        r_scanning <= 1'b0;
                    end
                    if (cmp_send) begin
                        r_run_open <= 1'b1;
                        if (cmp_lead) begin
                            r_res[0] <= mk_out(CMD_CURSOR_LO, r_scan_addr[7:0], 1'b0, scan_done);
                            r_res[1] <= mk_out(CMD_CURSOR_HI, r_scan_addr[15:8], 1'b0, scan_done);
                            r_res[2] <= mk_out(CMD_DATA, cmp_data, 1'b1, scan_done);
                        end else begin
                            r_res[0] <= mk_out(CMD_DATA, cmp_data, 1'b1, scan_done);
                        end
                        r_state <= S_EMIT;
                    end else begin
                        r_run_open <= 1'b0;
                        r_res[0]   <= mk_out(CMD_NONE, 8'h00, 1'b1, 1'b1);
                        r_state    <= scan_done ? S_EMIT : S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out     <= r_res[r_res_ptr];
                        r_res_ptr <= r_res_ptr + 2'd1;
                        if (r_res[r_res_ptr].last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `LCDSD_ASSERT_NOW(a_none_closes_frame, i_clk, i_rst_n,
        o_out_valid && (o_out_data.command == CMD_NONE),
        o_out_data.last && o_out_data.frame_done, "empty beat must end a frame")
    `LCDSD_ASSERT_NEXT(a_hi_follows_lo, i_clk, i_rst_n,
        o_out_valid && i_out_ready && (o_out_data.command == CMD_CURSOR_LO),
        o_out_valid && (o_out_data.command == CMD_CURSOR_HI), "cursor high must follow low")
    `LCDSD_ASSERT_NOW(a_no_beat_in_init, i_clk, i_rst_n,
        r_state == S_INIT, !o_out_valid && !o_in_ready, "activity during clearing pass")

endmodule

`default_nettype wire

/* sv/lcdsd_ram.sv */
`default_nettype none

module lcdsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_en,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_addr];
            end
        end
    end

endmodule

`default_nettype wire

/* sv/lcdsd_rem.sv */
`default_nettype none

// Bit-serial restoring remainder: one dividend bit per cycle.
module lcdsd_rem (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [8:0] i_dividend,
    input  wire logic [7:0] i_divisor,
    output logic            o_done,
    output logic      [7:0] o_rem
);

    localparam logic [3:0] LAST_STEP = 4'd8;

    logic       r_busy;
    logic       r_done;
    logic [3:0] r_cnt;
    logic [8:0] r_num;
    logic [7:0] r_rem;
    logic [7:0] r_div;
    logic [8:0] trial;
    logic [8:0] n_part;

    always_comb begin
        trial = {r_rem, r_num[8]};
        if (trial >= {1'b0, r_div}) begin
            n_part = trial - {1'b0, r_div};
        end else begin
            n_part = trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                // The partial remainder stays below the divisor, so 8 bits hold it.
                r_rem <= n_part[7:0];
                r_num <= {r_num[7:0], 1'b0};
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire
